>>> rtl/ttbd_pkg.sv
// shared types, codes and pixel conversion functions of the tiled texture decoder
`default_nettype none
package ttbd_pkg;

  localparam logic [3:0] FMT_I4     = 4'd0;
  localparam logic [3:0] FMT_I8     = 4'd1;
  localparam logic [3:0] FMT_RGB5A3 = 4'd5;
  localparam logic [3:0] FMT_C4     = 4'd8;
  localparam logic [3:0] FMT_C8     = 4'd9;
  localparam logic [3:0] FMT_DXT1   = 4'd14;

  localparam logic [1:0] PAL_A8     = 2'd0;
  localparam logic [1:0] PAL_RGB565 = 2'd1;
  localparam logic [1:0] PAL_RGB5A3 = 2'd2;

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_UNSUPP  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_FORMAT  = 2'd0;
  localparam logic [1:0] REG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_PALFMT  = 2'd3;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  typedef enum logic [1:0] {
    KIND_ERROR,
    KIND_PLAIN,
    KIND_PALETTE,
    KIND_DXT
  } kind_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  palette_index;
    logic [15:0] palette_raw;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [31:0] pixel_color;
    logic [1:0]  status;
    logic        last_of_image;
  } out_item_t;

  // one classified byte, up to four pixels
  typedef struct packed {
    kind_e            kind;
    logic [2:0]       count;      // pixels minus one
    logic [10:0]      base_x;
    logic [10:0]      base_y;
    logic [3:0][1:0]  out_flags;  // per pixel: outside, last
    logic [3:0][31:0] color;      // plain colors
    logic [3:0][7:0]  pal_idx;    // palette lookups
    logic [31:0]      endpoints;
    logic [7:0]       dxt_idx;
  } job_t;

  function automatic logic [31:0] conv_rgb5a3(input logic [15:0] c);
    logic [31:0] r;
    r = '0;
    if (c[15]) begin
      r = {c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2], 8'hFF};
    end else begin
      r = {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0], c[14:12], c[14:12], c[14:13]};
    end
    return r;
  endfunction

  function automatic logic [31:0] conv_rgb565(input logic [15:0] c);
    return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2], 8'hFF};
  endfunction

  function automatic logic [31:0] grey(input logic [7:0] v);
    return {v, v, v, 8'hFF};
  endfunction

  function automatic logic [23:0] expand565(input logic [15:0] c);
    return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
  endfunction

  // divide a value below 766 by three
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [31:0] dxt_color(input logic [31:0] ep, input logic [1:0] idx);
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] m;
    logic [31:0] r;
    a = expand565(ep[31:16]);
    b = expand565(ep[15:0]);
    m = '0;
    for (int i = 0; i < 3; i++) begin
      if (ep[31:16] > ep[15:0]) begin
        if (idx == 2'd2) begin
          m[i*8 +: 8] = div3({1'b0, a[i*8 +: 8], 1'b0} + 10'(b[i*8 +: 8]));
        end else begin
          m[i*8 +: 8] = div3({1'b0, b[i*8 +: 8], 1'b0} + 10'(a[i*8 +: 8]));
        end
      end else begin
        m[i*8 +: 8] = 8'((9'(a[i*8 +: 8]) + 9'(b[i*8 +: 8])) >> 1);
      end
    end
    case (idx)
      2'd0:    r = {a, 8'hFF};
      2'd1:    r = {b, 8'hFF};
      default: r = (idx == 2'd3 && !(ep[31:16] > ep[15:0])) ? 32'h0 : {m, 8'hFF};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tiled_texture_block_decoder.sv
// top level of the tiled texture decoder
//
//   channel  handshake        payload
//   input    push_i / full_o  in_i  (command, palette slot and raw, data byte)
//   result   pop_i / empty_o  out_o (x, y, color, status, last)
//   config   apb psel/penable registers at 4*i
//
// one pixel leaves per cycle while the receiver pops; a byte yields 0 to 4 pixels
// (one for an error), sent one at a time by the single pixel lane in the back end.
// a byte enters the job queue the cycle it is pushed; pixels then pass s1_q, out_q.
// reset clears position and queue; palette contents stay undefined until loaded.
// full_o is high for a data byte while the queue is full, and for a palette load
// until the queue is empty; a stalled result stalls the back end, then the queue fills.
`default_nettype none
module tiled_texture_block_decoder #(
  parameter int MaxDimension = 1024,
  parameter int PaletteDepth = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                push_i,
  input  wire ttbd_pkg::in_item_t  in_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output ttbd_pkg::out_item_t      out_o
);
  import ttbd_pkg::*;

  logic job_full, job_push, job_empty, job_pop, accept;
  job_t job_in, job_out;
  logic pal_we;
  logic [7:0] pal_waddr;
  logic [31:0] pal_wdata;

  assign pready = 1'b1;
  assign full_o = (in_i.command == CMD_DATA) ? job_full : !job_empty;

  ttbd_front #(.MaxDimension(MaxDimension), .PaletteDepth(PaletteDepth)) u_front (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .push_i, .in_i, .accept_o(accept), .job_full_i(job_full), .job_empty_i(job_empty),
    .job_push_o(job_push), .job_o(job_in),
    .pal_we_o(pal_we), .pal_waddr_o(pal_waddr), .pal_wdata_o(pal_wdata)
  );

  ttbd_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_push), .data_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .empty_o(job_empty), .data_o(job_out)
  );

  ttbd_back #(.PaletteDepth(PaletteDepth)) u_back (
    .clk_i, .rst_ni, .pal_we_i(pal_we), .pal_waddr_i(pal_waddr), .pal_wdata_i(pal_wdata),
    .job_empty_i(job_empty), .job_i(job_out), .job_pop_o(job_pop),
    .empty_o, .pop_i, .out_o
  );
endmodule
`default_nettype wire

>>> rtl/ttbd_front.sv
// front end: configuration registers, palette loads, stream position and byte classification
`default_nettype none
module ttbd_front #(
  parameter int MaxDimension = 1024,
  parameter int PaletteDepth = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  input  wire logic              push_i,
  input  wire ttbd_pkg::in_item_t in_i,
  output logic                   accept_o,
  input  wire logic              job_full_i,
  input  wire logic              job_empty_i,
  output logic                   job_push_o,
  output ttbd_pkg::job_t         job_o,
  output logic                   pal_we_o,
  output logic [7:0]             pal_waddr_o,
  output logic [31:0]            pal_wdata_o
);
  import ttbd_pkg::*;

  logic [3:0]  fmt_q;
  logic [10:0] width_q, height_q;
  logic [1:0]  palfmt_q;
  logic [10:0] tcol_q, tcol_d, trow_q, trow_d;
  logic [4:0]  byte_q, byte_d;
  logic [7:0]  held_q, held_d;
  logic [31:0] ep_q, ep_d;

  logic cfg_wr;
  logic [1:0] reg_idx;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      REG_FORMAT: prdata = {28'd0, fmt_q};
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {21'd0, height_q};
      default:    prdata = {30'd0, palfmt_q};
    endcase
  end

  logic ok, is_data;
  logic [4:0] tw, th;
  logic [10:0] bx, by;
  logic [2:0] npix;

  assign is_data  = in_i.command == CMD_DATA;
  // a palette load waits until every queued byte has done its palette reads
  assign accept_o = push_i && (is_data ? !job_full_i : job_empty_i);

  always_comb begin
    ok = (fmt_q == FMT_I4) || (fmt_q == FMT_I8) || (fmt_q == FMT_RGB5A3) ||
         (fmt_q == FMT_C4) || (fmt_q == FMT_C8) || (fmt_q == FMT_DXT1);
    if (width_q == 11'd0 || height_q == 11'd0 ||
        32'(width_q) > MaxDimension || 32'(height_q) > MaxDimension) ok = 1'b0;
    if (fmt_q == FMT_DXT1 && (width_q[1:0] != 2'd0 || height_q[1:0] != 2'd0)) ok = 1'b0;
    if (fmt_q == FMT_I8 || fmt_q == FMT_C8) begin
      tw = 5'd8; th = 5'd4;
    end else if (fmt_q == FMT_RGB5A3) begin
      tw = 5'd4; th = 5'd4;
    end else begin
      tw = 5'd8; th = 5'd8;
    end
  end

  always_comb begin
    logic [7:0] d;
    logic [10:0] px, py;
    logic last_tile;
    d = in_i.data_byte;
    job_o = '0;
    bx = tcol_q;
    by = trow_q;
    npix = 3'd0;
    held_d = held_q;
    ep_d = ep_q;
    case (fmt_q)
      FMT_I4, FMT_C4: begin
        bx = tcol_q + {8'd0, byte_q[1:0], 1'b0};
        by = trow_q + {8'd0, byte_q[4:2]};
        npix = 3'd2;
        job_o.kind = (fmt_q == FMT_I4) ? KIND_PLAIN : KIND_PALETTE;
        job_o.color[0] = grey({d[7:4], d[7:4]});
        job_o.color[1] = grey({d[3:0], d[3:0]});
        job_o.pal_idx[0] = {4'd0, d[7:4]};
        job_o.pal_idx[1] = {4'd0, d[3:0]};
      end
      FMT_I8, FMT_C8: begin
        bx = tcol_q + {8'd0, byte_q[2:0]};
        by = trow_q + {9'd0, byte_q[4:3]};
        npix = 3'd1;
        job_o.kind = (fmt_q == FMT_I8) ? KIND_PLAIN : KIND_PALETTE;
        job_o.color[0] = grey(d);
        job_o.pal_idx[0] = d;
      end
      FMT_RGB5A3: begin
        bx = tcol_q + {9'd0, byte_q[2:1]};
        by = trow_q + {9'd0, byte_q[4:3]};
        job_o.kind = KIND_PLAIN;
        job_o.color[0] = conv_rgb5a3({held_q, d});
        if (!byte_q[0]) begin
          held_d = d;
        end else begin
          npix = 3'd1;
        end
      end
      default: begin
        bx = tcol_q + {8'd0, byte_q[3], 2'd0};
        by = trow_q + {8'd0, byte_q[4], byte_q[1:0]};
        job_o.kind = KIND_DXT;
        if (!byte_q[2]) begin
          ep_d = {ep_q[23:0], d};
        end else begin
          npix = 3'd4;
        end
      end
    endcase
    job_o.endpoints = ep_q;
    job_o.dxt_idx = d;
    last_tile = (byte_q == 5'd31) && (12'(tcol_q) + 12'(tw) >= 12'(width_q)) &&
                (12'(trow_q) + 12'(th) >= 12'(height_q));
    job_o.base_x = bx;
    job_o.base_y = by;
    job_o.count = npix - 3'd1;
    for (int k = 0; k < 4; k++) begin
      px = bx + 11'(k);
      py = by;
      job_o.out_flags[k] = {(px >= width_q) || (py >= height_q),
                            last_tile && (3'(k) == npix - 3'd1)};
    end
    if (!ok) begin
      job_o = '0;
      job_o.kind = KIND_ERROR;
    end
  end

  logic data_go;
  assign data_go = accept_o && is_data;
  assign job_push_o = data_go && (!ok || npix != 3'd0);

  always_comb begin
    logic [11:0] nc, nr;
    tcol_d = tcol_q;
    trow_d = trow_q;
    byte_d = byte_q;
    nc = 12'(tcol_q) + 12'(tw);
    nr = 12'(trow_q) + 12'(th);
    if (data_go && ok) begin
      byte_d = byte_q + 5'd1;
      if (byte_q == 5'd31) begin
        if (nc >= 12'(width_q)) begin
          tcol_d = '0;
          trow_d = (nr >= 12'(height_q)) ? 11'd0 : nr[10:0];
        end else begin
          tcol_d = nc[10:0];
        end
      end
    end
    if (cfg_wr && reg_idx != REG_PALFMT) begin
      tcol_d = '0; trow_d = '0; byte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_I4; width_q <= 11'd8; height_q <= 11'd8; palfmt_q <= PAL_A8;
      tcol_q <= '0; trow_q <= '0; byte_q <= '0; held_q <= '0; ep_q <= '0;
    end else begin
      tcol_q <= tcol_d; trow_q <= trow_d; byte_q <= byte_d;
      if (data_go && ok) begin
        held_q <= held_d; ep_q <= ep_d;
      end
      if (cfg_wr) begin
        case (reg_idx)
          REG_FORMAT: fmt_q <= pwdata[3:0];
          REG_WIDTH:  width_q <= pwdata[10:0];
          REG_HEIGHT: height_q <= pwdata[10:0];
          default:    palfmt_q <= pwdata[1:0];
        endcase
      end
    end
  end

  // palette loads convert on the way in
  always_comb begin
    logic [15:0] r;
    r = in_i.palette_raw;
    pal_waddr_o = in_i.palette_index;
    pal_we_o = accept_o && !is_data && 32'(in_i.palette_index) < PaletteDepth &&
               palfmt_q != 2'd3;
    case (palfmt_q)
      PAL_A8:     pal_wdata_o = {r[7:0], r[7:0], r[7:0], r[7:0]};
      PAL_RGB565: pal_wdata_o = conv_rgb565(r);
      default:    pal_wdata_o = conv_rgb5a3(r);
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ttbd_queue.sv
// short job queue between front and back
`default_nettype none
module ttbd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ttbd_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output ttbd_pkg::job_t     data_o
);
  import ttbd_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule
`default_nettype wire

>>> rtl/ttbd_back.sv
// back end: palette memory, per-pixel color and result output register
`default_nettype none
module ttbd_back #(
  parameter int PaletteDepth = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pal_we_i,
  input  wire logic [7:0]      pal_waddr_i,
  input  wire logic [31:0]     pal_wdata_i,
  input  wire logic            job_empty_i,
  input  wire ttbd_pkg::job_t  job_i,
  output logic                 job_pop_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output ttbd_pkg::out_item_t  out_o
);
  import ttbd_pkg::*;

  localparam int AW = $clog2(PaletteDepth);

  logic [31:0] pal_mem [PaletteDepth];
  logic [31:0] pal_rd_q;

  // stage 1: one pixel chosen, palette read issued
  logic        s1_v_q;
  logic [2:0]  k_q;
  out_item_t   s1_q;
  kind_e       s1_kind_q;
  logic [31:0] s1_color_q;
  logic        out_v_q;
  out_item_t   out_q;
  logic        adv;
  logic        s1_go;
  logic [7:0]  ridx_q;

  assign empty_o = !out_v_q;
  assign out_o   = out_q;
  // the output register is free, or being drained this cycle
  assign adv     = !out_v_q || pop_i;
  assign s1_go   = !s1_v_q || adv;

  logic take;
  assign take = s1_go && !job_empty_i;
  assign job_pop_o = take && (k_q == job_i.count || job_i.kind == KIND_ERROR);

  logic [7:0] ridx;
  assign ridx = job_i.pal_idx[k_q[1:0]];

  always_ff @(posedge clk_i) begin
    if (pal_we_i) pal_mem[pal_waddr_i[AW-1:0]] <= pal_wdata_i;
    if (take) pal_rd_q <= pal_mem[ridx[AW-1:0]];
    if (take) begin
      s1_kind_q <= job_i.kind;
      s1_q.pixel_x <= job_i.base_x + 11'(k_q);
      s1_q.pixel_y <= job_i.base_y;
      s1_q.status <= job_i.kind == KIND_ERROR ? ST_UNSUPP :
                     job_i.out_flags[k_q[1:0]][1] ? ST_OUTSIDE : ST_VALID;
      s1_q.last_of_image <= job_i.out_flags[k_q[1:0]][0];
      if (job_i.kind == KIND_DXT) begin
        s1_color_q <= dxt_color(job_i.endpoints, job_i.dxt_idx[3'd6 - {k_q[1:0], 1'b0} +: 2]);
      end else begin
        s1_color_q <= job_i.color[k_q[1:0]];
      end
    end
    if (s1_v_q && adv) begin
      out_q.pixel_x <= s1_q.pixel_x;
      out_q.pixel_y <= s1_q.pixel_y;
      out_q.status <= s1_q.status;
      out_q.last_of_image <= s1_q.last_of_image;
      case (s1_kind_q)
        KIND_ERROR:   out_q.pixel_color <= '0;
        KIND_PALETTE: out_q.pixel_color <= (32'(ridx_q) < PaletteDepth) ? pal_rd_q : 32'h0;
        default:      out_q.pixel_color <= s1_color_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) ridx_q <= ridx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0; s1_v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (take) k_q <= job_pop_o ? 3'd0 : k_q + 3'd1;
      if (s1_go) s1_v_q <= take;
      if (adv) out_v_q <= s1_v_q;
    end
  end
endmodule
`default_nettype wire

>>> test/tiled_texture_block_decoder_checker.sv
// pixel predictor and result checker for the tiled texture decoder testbench
`timescale 1ns / 100ps
module tiled_texture_block_decoder_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  input  logic                 pready,
  input  logic                 push_i,
  input  ttbd_pkg::in_item_t   in_i,
  input  logic                 full_o,
  input  logic                 pop_i,
  input  logic                 empty_o,
  input  ttbd_pkg::out_item_t  out_o,
  output int                   errors_o,
  output int                   pending_o,
  output int                   pixels_checked_o
);
  import ttbd_pkg::*;

  logic [3:0]  fmt_q;
  logic [10:0] width_q;
  logic [10:0] height_q;
  logic [1:0]  palfmt_q;
  logic [31:0] palette_mem [256];
  int          tile_x;
  int          tile_y;
  int          tile_byte;
  logic [7:0]  rgb_high;
  logic [31:0] dxt_endpoints;

  out_item_t   expected_pixels [$];

  function automatic logic [31:0] from_rgb5a3(logic [15:0] c);
    logic [4:0] r5, g5, b5;
    logic [3:0] r4, g4, b4;
    logic [2:0] a3;
    r5 = c[14:10]; g5 = c[9:5]; b5 = c[4:0];
    r4 = c[11:8]; g4 = c[7:4]; b4 = c[3:0]; a3 = c[14:12];
    if (c[15]) begin
      return {r5, r5[4:2], g5, g5[4:2], b5, b5[4:2], 8'hFF};
    end
    return {r4, r4, g4, g4, b4, b4, a3, a3, a3[2:1]};
  endfunction

  function automatic logic [31:0] from_rgb565(logic [15:0] c);
    logic [4:0] r5, b5;
    logic [5:0] g6;
    r5 = c[15:11]; g6 = c[10:5]; b5 = c[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2], 8'hFF};
  endfunction

  function automatic int chan565(logic [15:0] c, int ch);
    case (ch)
      0:       return {c[15:11], c[15:13]};
      1:       return {c[10:5], c[10:9]};
      default: return {c[4:0], c[4:2]};
    endcase
  endfunction

  function automatic logic [31:0] block_color(logic [31:0] ep, logic [1:0] sel);
    logic [15:0] c0, c1;
    logic [31:0] r;
    int a, b, m;
    c0 = ep[31:16]; c1 = ep[15:0];
    r = 32'hFF;
    if (sel == 2'd3 && c0 <= c1) return 32'h0;
    for (int ch = 0; ch < 3; ch++) begin
      a = chan565(c0, ch);
      b = chan565(c1, ch);
      case (sel)
        2'd0: m = a;
        2'd1: m = b;
        2'd2: m = (c0 > c1) ? (2 * a + b) / 3 : (a + b) / 2;
        default: m = (2 * b + a) / 3;
      endcase
      r[31 - 8 * ch -: 8] = m[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] palette_lookup(int idx);
    return (idx < 256) ? palette_mem[idx] : 32'h0;
  endfunction

  // works out the pixels that one data byte yields and advances the stream
  function automatic void decode_byte(logic [7:0] d);
    int w, h, b, tw, th, n;
    int dx [4];
    int dy [4];
    logic [31:0] col [4];
    bit ok, last_tile;
    out_item_t px;
    w = width_q; h = height_q; n = 0;
    ok = fmt_q inside {FMT_I4, FMT_I8, FMT_RGB5A3, FMT_C4, FMT_C8, FMT_DXT1};
    if (w == 0 || h == 0 || w > 1024 || h > 1024) ok = 0;
    if (fmt_q == FMT_DXT1 && ((w % 4) != 0 || (h % 4) != 0)) ok = 0;
    if (!ok) begin
      px = '0;
      px.status = ST_UNSUPP;
      expected_pixels.push_back(px);
      return;
    end
    b = tile_byte % 32;
    if (fmt_q == FMT_I8 || fmt_q == FMT_C8) begin
      tw = 8; th = 4;
    end else if (fmt_q == FMT_RGB5A3) begin
      tw = 4; th = 4;
    end else begin
      tw = 8; th = 8;
    end
    case (fmt_q)
      FMT_I4, FMT_C4: begin
        dx[0] = (b % 4) * 2; dy[0] = b / 4;
        dx[1] = dx[0] + 1;   dy[1] = dy[0];
        if (fmt_q == FMT_I4) begin
          col[0] = {{3{d[7:4], d[7:4]}}, 8'hFF};
          col[1] = {{3{d[3:0], d[3:0]}}, 8'hFF};
        end else begin
          col[0] = palette_lookup(d[7:4]);
          col[1] = palette_lookup(d[3:0]);
        end
        n = 2;
      end
      FMT_I8, FMT_C8: begin
        dx[0] = b % 8; dy[0] = b / 8;
        col[0] = (fmt_q == FMT_I8) ? {d, d, d, 8'hFF} : palette_lookup(d);
        n = 1;
      end
      FMT_RGB5A3: begin
        if (b % 2 == 0) begin
          rgb_high = d;
        end else begin
          dx[0] = (b / 2) % 4; dy[0] = b / 8;
          col[0] = from_rgb5a3({rgb_high, d});
          n = 1;
        end
      end
      default: begin
        // dxt1: four endpoint bytes then four row index bytes per sub-block
        if (b % 8 < 4) begin
          dxt_endpoints = {dxt_endpoints[23:0], d};
        end else begin
          for (int k = 0; k < 4; k++) begin
            dx[k] = ((b / 8) % 2) * 4 + k;
            dy[k] = (b / 16) * 4 + (b % 8 - 4);
            col[k] = block_color(dxt_endpoints, d[7 - 2 * k -: 2]);
          end
          n = 4;
        end
      end
    endcase
    last_tile = (b == 31) && (tile_x + tw >= w) && (tile_y + th >= h);
    for (int k = 0; k < n; k++) begin
      px.pixel_x       = 11'(tile_x + dx[k]);
      px.pixel_y       = 11'(tile_y + dy[k]);
      px.pixel_color   = col[k];
      px.status        = (tile_x + dx[k] >= w || tile_y + dy[k] >= h) ? ST_OUTSIDE : ST_VALID;
      px.last_of_image = last_tile && (k == n - 1);
      expected_pixels.push_back(px);
    end
    tile_byte = b + 1;
    if (tile_byte >= 32) begin
      tile_byte = 0;
      tile_x += tw;
      if (tile_x >= w) begin
        tile_x = 0;
        tile_y += th;
        if (tile_y >= h) tile_y = 0;
      end
    end
  endfunction

  function automatic void load_palette(logic [7:0] idx, logic [15:0] raw);
    case (palfmt_q)
      PAL_A8:     palette_mem[idx] = {4{raw[7:0]}};
      PAL_RGB565: palette_mem[idx] = from_rgb565(raw);
      PAL_RGB5A3: palette_mem[idx] = from_rgb5a3(raw);
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      fmt_q = FMT_I4; width_q = 11'd8; height_q = 11'd8; palfmt_q = PAL_A8;
      for (int i = 0; i < 256; i++) palette_mem[i] = '0;
      tile_x = 0; tile_y = 0; tile_byte = 0;
      rgb_high = '0; dxt_endpoints = '0;
      expected_pixels.delete();
      errors_o = 0; pending_o = 0; pixels_checked_o = 0;
    end else begin
      if (pop_i && !empty_o) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel transfer with nothing expected: x=%0d y=%0d",
                 out_o.pixel_x, out_o.pixel_y);
          errors_o++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.pixel_x, out_o.pixel_x);
          check_field("pixel_y", want.pixel_y, out_o.pixel_y);
          check_field("pixel_color", want.pixel_color, out_o.pixel_color);
          check_field("status", want.status, out_o.status);
          check_field("last_of_image", want.last_of_image, out_o.last_of_image);
          pixels_checked_o++;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FORMAT: fmt_q = pwdata[3:0];
          REG_WIDTH:  width_q = pwdata[10:0];
          REG_HEIGHT: height_q = pwdata[10:0];
          default:    palfmt_q = pwdata[1:0];
        endcase
        if (paddr[3:2] != REG_PALFMT) begin
          tile_x = 0; tile_y = 0; tile_byte = 0;
        end
      end
      if (push_i && !full_o) begin
        if (in_i.command == CMD_PALETTE) load_palette(in_i.palette_index, in_i.palette_raw);
        else decode_byte(in_i.data_byte);
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

>>> test/tiled_texture_block_decoder_tb.sv
// stimulus and verdict for the tiled texture decoder
`timescale 1ns / 100ps
module tiled_texture_block_decoder_tb;
  import ttbd_pkg::*;

  localparam int IdleLimit = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push_i;
  in_item_t    in_i;
  logic        full_o;
  logic        pop_i;
  logic        empty_o;
  out_item_t   out_o;

  int errors, pending, pixels_checked;
  int data_sent, loads_sent, setups_done;
  int burst_left;
  int idle_cycles;
  int pop_mode, pop_tick;

  tiled_texture_block_decoder dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push_i, .in_i, .full_o, .pop_i, .empty_o, .out_o
  );

  tiled_texture_block_decoder_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .push_i, .in_i, .full_o, .pop_i, .empty_o, .out_o,
    .errors_o(errors), .pending_o(pending), .pixels_checked_o(pixels_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stall pattern, switching at random among four characters
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0; pop_mode <= 0; pop_tick <= 0;
    end else begin
      pop_tick <= pop_tick + 1;
      if (pop_tick % 64 == 63) pop_mode <= int'($urandom_range(0, 3));
      case (pop_mode)
        0:       pop_i <= 1'b1;
        1:       pop_i <= 1'($urandom_range(0, 1));
        2:       pop_i <= ($urandom_range(0, 3) == 0);
        default: pop_i <= (pop_tick % 8 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tiled_texture_block_decoder: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(in_item_t it);
    if (burst_left == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    push_i <= 1'b1;
    in_i   <= it;
    do @(posedge clk_i); while (full_o);
    burst_left--;
  endtask

  task automatic send_data(logic [7:0] d);
    in_item_t it;
    it = {CMD_DATA, 8'($urandom), 16'($urandom), d};
    push_item(it);
    data_sent++;
  endtask

  task automatic send_load(logic [7:0] idx, logic [15:0] raw);
    in_item_t it;
    it = {CMD_PALETTE, idx, raw, 8'($urandom)};
    push_item(it);
    loads_sent++;
  endtask

  task automatic drain();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // palette loads give no pixel, so allow the pipeline to settle
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic setup(logic [3:0] fmt, int w, int h, logic [1:0] pf);
    drain();
    reg_write(REG_FORMAT, 32'(fmt));
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_PALFMT, 32'(pf));
    @(posedge clk_i);
    setups_done++;
  endtask

  initial begin
    logic [3:0] fmt;
    int w, h, nbytes;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    push_i = 0; in_i = '0;
    data_sent = 0; loads_sent = 0; setups_done = 0; burst_left = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the low palette slots, then write some random slots in the other encodings
    setup(FMT_I4, 8, 8, PAL_RGB565);
    for (int i = 0; i < 32; i++) send_load(8'(i), 16'($urandom));
    setup(FMT_I4, 8, 8, PAL_RGB5A3);
    for (int i = 0; i < 16; i++) send_load(8'($urandom_range(0, 255)), {i[0], 15'($urandom)});
    setup(FMT_I4, 8, 8, PAL_A8);
    send_load(8'd0, 16'hFFFF);
    send_load(8'd255, 16'h0000);

    // directed: field extremes, each format, both dxt1 modes, error cases
    send_data(8'h00); send_data(8'hFF);
    setup(FMT_I8, 8, 8, PAL_A8);
    send_data(8'h00); send_data(8'hFF);
    setup(FMT_RGB5A3, 4, 4, PAL_A8);
    send_data(8'hFF); send_data(8'hFF); send_data(8'h7F); send_data(8'h00);
    setup(FMT_C4, 8, 8, PAL_A8);
    send_data(8'h0F);
    setup(FMT_C8, 8, 8, PAL_A8);
    send_data(8'hFF); send_data(8'h00);
    setup(FMT_DXT1, 8, 8, PAL_A8);
    send_data(8'hF8); send_data(8'h00); send_data(8'h00); send_data(8'h1F);
    for (int i = 0; i < 4; i++) send_data(8'hE4);
    send_data(8'h00); send_data(8'h1F); send_data(8'hF8); send_data(8'h00);
    send_data(8'hE4); send_data(8'h1B);
    setup(4'd3, 8, 8, PAL_A8);
    send_data(8'h5A);
    setup(FMT_DXT1, 6, 8, PAL_A8);
    send_data(8'h5A);
    setup(FMT_I8, 0, 8, PAL_A8);
    send_data(8'h5A);
    setup(FMT_I8, 2047, 2047, PAL_A8);
    send_data(8'h5A);
    setup(FMT_I8, 1, 1, PAL_A8);
    send_data(8'h11); send_data(8'h22);
    setup(FMT_I4, 1024, 1024, PAL_A8);
    send_data(8'hA5);

    // random: mostly whole tiles of valid geometry, some noise and error setups
    while (data_sent < 140) begin
      case ($urandom_range(0, 9))
        0:       fmt = 4'($urandom);
        1, 2:    fmt = FMT_DXT1;
        3:       fmt = FMT_I4;
        4:       fmt = FMT_I8;
        5:       fmt = FMT_RGB5A3;
        6, 7:    fmt = FMT_C4;
        default: fmt = FMT_C8;
      endcase
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 20);
      if (fmt == FMT_DXT1 && $urandom_range(0, 7) != 0) begin
        w = 4 * $urandom_range(1, 4);
        h = 4 * $urandom_range(1, 4);
      end
      if ($urandom_range(0, 15) == 0) w = 1024;
      if ($urandom_range(0, 15) == 0) h = 1024;
      setup(fmt, w, h, 2'($urandom_range(0, 2)));
      nbytes = 32 * $urandom_range(1, 2) - (($urandom_range(0, 3) == 0) ? 5 : 0);
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(0, 9) == 0) send_load(8'($urandom), 16'($urandom));
        // palette indexes stay within the filled slots
        if (fmt == FMT_C8) send_data(8'($urandom) & 8'h1F);
        else send_data(8'($urandom));
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    $display("run covered %0d data bytes and %0d palette loads over %0d register setups",
             data_sent, loads_sent, setups_done);
    $display("%0d pixels compared, %0d still expected", pixels_checked, pending);
    if (errors == 0 && pending == 0) begin
      $display("tiled_texture_block_decoder: match");
    end else begin
      $display("tiled_texture_block_decoder: mismatch");
    end
    $finish;
  end

endmodule
